### src/hng_pkg.sv
// Shared types, constants and helper functions of the hysteresis noise gate.
package hng_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int COEF_W     = 25;
    localparam int THR_W      = 23;
    localparam int STORE_W    = 32;
    localparam int DIFF_W     = 33;
    localparam int PROD_W     = COEF_W + 1 + DIFF_W;
    localparam int FRAC_W     = 24;
    localparam int Q_W        = PROD_W - FRAC_W;
    localparam int SUM_W      = 36;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;

    localparam logic [COEF_W-1:0] ONE_Q24 = 25'h100_0000;

    localparam logic signed [STORE_W-1:0] STORE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [STORE_W-1:0] STORE_MIN = 32'sh8000_0000;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_SC_HP_COEFF     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SC_LP_COEFF     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENV_ATTACK      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ENV_RELEASE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_OPEN_RATE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_CLOSE_RATE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OPEN_THRESHOLD  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CLOSE_THRESHOLD = 3'd7;

    localparam logic [COEF_W-1:0] RST_SC_HP_COEFF     = 25'd216780;
    localparam logic [COEF_W-1:0] RST_SC_LP_COEFF     = 25'd4952870;
    localparam logic [COEF_W-1:0] RST_ENV_ATTACK      = 25'd231400;
    localparam logic [COEF_W-1:0] RST_ENV_RELEASE     = 25'd1589;
    localparam logic [COEF_W-1:0] RST_GAIN_OPEN_RATE  = 25'd345880;
    localparam logic [COEF_W-1:0] RST_GAIN_CLOSE_RATE = 25'd1942;
    localparam logic [THR_W-1:0]  RST_OPEN_THRESHOLD  = 23'd8389;
    localparam logic [THR_W-1:0]  RST_CLOSE_THRESHOLD = 23'd3775;

    typedef struct packed {
        logic [COEF_W-1:0] sc_hp_coeff;
        logic [COEF_W-1:0] sc_lp_coeff;
        logic [COEF_W-1:0] env_attack;
        logic [COEF_W-1:0] env_release;
        logic [COEF_W-1:0] gain_open_rate;
        logic [COEF_W-1:0] gain_close_rate;
        logic [THR_W-1:0]  open_threshold;
        logic [THR_W-1:0]  close_threshold;
    } hng_cfg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HP_D, S_HP_M, S_HP_U,
        S_LP_D, S_LP_M, S_LP_U,
        S_EN_D, S_EN_M, S_EN_U,
        S_GN_D, S_GN_M, S_GN_U,
        S_WT_M,
        S_OUT
    } hng_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_HP_D, OP_HP_M, OP_HP_U,
        OP_LP_D, OP_LP_M, OP_LP_U,
        OP_EN_D, OP_EN_M, OP_EN_U,
        OP_GN_D, OP_GN_M, OP_GN_U,
        OP_WT_M,
        OP_OUT
    } hng_op_t;

    typedef struct packed {
        hng_op_t op;
    } hng_cmd_t;

    typedef struct packed {
        logic gate_on;
        logic out_free;
    } hng_sts_t;

    function automatic logic signed [STORE_W-1:0] sat_store(
        input logic signed [SUM_W-1:0] v
    );
        logic signed [STORE_W-1:0] r;
        if (v > SUM_W'(STORE_MAX))
            r = STORE_MAX;
        else if (v < SUM_W'(STORE_MIN))
            r = STORE_MIN;
        else
            r = v[STORE_W-1:0];
        return r;
    endfunction

    // Coefficients above 1.0 count as 1.0
    function automatic logic [COEF_W-1:0] coef_limit(input logic [COEF_W-1:0] c);
        return (c > ONE_Q24) ? ONE_Q24 : c;
    endfunction

endpackage

### src/hng_if.sv
// Stream interfaces of the noise gate: sample channel and result channel.
interface hng_in_if;
    import hng_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] dry_sample;
    logic signed [SAMPLE_W-1:0] wet_sample;
    logic                       gate_on;

    modport source (output valid, output dry_sample, output wet_sample, output gate_on,
                    input ready);
    modport sink   (input valid, input dry_sample, input wet_sample, input gate_on,
                    output ready);
endinterface

interface hng_out_if;
    import hng_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] gated_sample;
    logic                       gate_is_open;

    modport source (output valid, output gated_sample, output gate_is_open, input ready);
    modport sink   (input valid, input gated_sample, input gate_is_open, output ready);
endinterface

### src/hng_cfg.sv
// Configuration register file with reset values.
module hng_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [hng_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hng_pkg::CFG_DATA_W-1:0]     cfg_data,
    output hng_pkg::hng_cfg_t                  cfg
);
    import hng_pkg::*;

    hng_cfg_t cfg_reg;
    hng_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SC_HP_COEFF:     cfg_next.sc_hp_coeff     = cfg_data[COEF_W-1:0];
                REG_SC_LP_COEFF:     cfg_next.sc_lp_coeff     = cfg_data[COEF_W-1:0];
                REG_ENV_ATTACK:      cfg_next.env_attack      = cfg_data[COEF_W-1:0];
                REG_ENV_RELEASE:     cfg_next.env_release     = cfg_data[COEF_W-1:0];
                REG_GAIN_OPEN_RATE:  cfg_next.gain_open_rate  = cfg_data[COEF_W-1:0];
                REG_GAIN_CLOSE_RATE: cfg_next.gain_close_rate = cfg_data[COEF_W-1:0];
                REG_OPEN_THRESHOLD:  cfg_next.open_threshold  = cfg_data[THR_W-1:0];
                REG_CLOSE_THRESHOLD: cfg_next.close_threshold = cfg_data[THR_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sc_hp_coeff     <= RST_SC_HP_COEFF;
            cfg_reg.sc_lp_coeff     <= RST_SC_LP_COEFF;
            cfg_reg.env_attack      <= RST_ENV_ATTACK;
            cfg_reg.env_release     <= RST_ENV_RELEASE;
            cfg_reg.gain_open_rate  <= RST_GAIN_OPEN_RATE;
            cfg_reg.gain_close_rate <= RST_GAIN_CLOSE_RATE;
            cfg_reg.open_threshold  <= RST_OPEN_THRESHOLD;
            cfg_reg.close_threshold <= RST_CLOSE_THRESHOLD;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### src/hng_ctrl.sv
// Sequencer of the noise gate: steps the shared multiplier through one sample.
module hng_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  hng_pkg::hng_sts_t sts,
    output hng_pkg::hng_cmd_t cmd
);
    import hng_pkg::*;

    hng_state_t state_reg;
    hng_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_valid) state_next = S_HP_D;
            // bypassed samples skip the whole chain
            S_HP_D: state_next = sts.gate_on ? S_HP_M : S_OUT;
            S_HP_M: state_next = S_HP_U;
            S_HP_U: state_next = S_LP_D;
            S_LP_D: state_next = S_LP_M;
            S_LP_M: state_next = S_LP_U;
            S_LP_U: state_next = S_EN_D;
            S_EN_D: state_next = S_EN_M;
            S_EN_M: state_next = S_EN_U;
            S_EN_U: state_next = S_GN_D;
            S_GN_D: state_next = S_GN_M;
            S_GN_M: state_next = S_GN_U;
            S_GN_U: state_next = S_WT_M;
            S_WT_M: state_next = S_OUT;
            S_OUT:  if (sts.out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd.op   = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) cmd.op = OP_LOAD;
            end
            S_HP_D: cmd.op = OP_HP_D;
            S_HP_M: cmd.op = OP_HP_M;
            S_HP_U: cmd.op = OP_HP_U;
            S_LP_D: cmd.op = OP_LP_D;
            S_LP_M: cmd.op = OP_LP_M;
            S_LP_U: cmd.op = OP_LP_U;
            S_EN_D: cmd.op = OP_EN_D;
            S_EN_M: cmd.op = OP_EN_M;
            S_EN_U: cmd.op = OP_EN_U;
            S_GN_D: cmd.op = OP_GN_D;
            S_GN_M: cmd.op = OP_GN_M;
            S_GN_U: cmd.op = OP_GN_U;
            S_WT_M: cmd.op = OP_WT_M;
            S_OUT:  if (sts.out_free) cmd.op = OP_OUT;
            default: cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

### src/hng_dp.sv
// Datapath of the noise gate: filter and envelope stores, gain, shared multiplier.
module hng_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  hng_pkg::hng_cmd_t                  cmd,
    output hng_pkg::hng_sts_t                  sts,
    input  hng_pkg::hng_cfg_t                  cfg,
    input  logic signed [hng_pkg::SAMPLE_W-1:0] dry_sample,
    input  logic signed [hng_pkg::SAMPLE_W-1:0] wet_sample,
    input  logic                               gate_on,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [hng_pkg::SAMPLE_W-1:0] gated_sample,
    output logic                               gate_is_open
);
    import hng_pkg::*;

    // sample latches and pipeline payload
    logic signed [SAMPLE_W-1:0] dry_reg, wet_reg;
    logic signed [DIFF_W-1:0]   diff_reg, diff_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic signed [SAMPLE_W-1:0] gated_reg, gated_next;
    logic                       open_out_reg, open_out_next;

    // model state
    logic                       gate_on_reg, gate_on_next;
    logic signed [STORE_W-1:0]  hp_reg, hp_next;
    logic signed [STORE_W-1:0]  lp_reg, lp_next;
    logic signed [STORE_W-1:0]  env_reg, env_next;
    logic [COEF_W-1:0]          gain_reg, gain_next;
    logic                       open_reg, open_next;
    logic                       out_valid_reg, out_valid_next;

    logic signed [STORE_W-1:0]  x_val;
    logic signed [STORE_W-1:0]  h_val;
    logic signed [STORE_W-1:0]  abs_val;
    logic signed [Q_W-1:0]      q_val;
    logic signed [SUM_W-1:0]    q_ext;
    logic signed [SUM_W-1:0]    store_sum;
    logic signed [STORE_W-1:0]  store_new;
    logic signed [SUM_W-1:0]    gain_sum;
    logic [COEF_W-1:0]          mul_a;
    logic signed [DIFF_W-1:0]   mul_b;
    logic [COEF_W-1:0]          target;
    logic signed [STORE_W-1:0]  open_lvl, close_lvl;

    assign x_val     = {dry_reg, 8'b0};
    assign h_val     = sat_store(SUM_W'(x_val) - SUM_W'(hp_reg));
    assign q_val     = prod_reg[PROD_W-1:FRAC_W];
    assign q_ext     = SUM_W'(q_val);
    assign target    = open_reg ? ONE_Q24 : '0;
    assign open_lvl  = $signed({1'b0, cfg.open_threshold, 8'b0});
    assign close_lvl = $signed({1'b0, cfg.close_threshold, 8'b0});
    assign gain_sum  = $signed({{(SUM_W-COEF_W){1'b0}}, gain_reg}) + q_ext;

    // rectify, folding the most negative value onto the largest positive one
    always_comb
    begin
        if (!lp_reg[STORE_W-1])
            abs_val = lp_reg;
        else if (lp_reg == STORE_MIN)
            abs_val = STORE_MAX;
        else
            abs_val = -lp_reg;
    end

    // one pole update: store plus floored product, for whichever store is in play
    always_comb
    begin
        case (cmd.op)
            OP_HP_U: store_sum = SUM_W'(hp_reg) + q_ext;
            OP_LP_U: store_sum = SUM_W'(lp_reg) + q_ext;
            default: store_sum = SUM_W'(env_reg) + q_ext;
        endcase
        store_new = sat_store(store_sum);
    end

    // shared multiplier operands; a rising difference picks the rise coefficient
    always_comb
    begin
        mul_a = '0;
        mul_b = diff_reg;
        case (cmd.op)
            OP_HP_M: mul_a = coef_limit(cfg.sc_hp_coeff);
            OP_LP_M: mul_a = coef_limit(cfg.sc_lp_coeff);
            OP_EN_M: mul_a = coef_limit((diff_reg > 0) ? cfg.env_attack : cfg.env_release);
            OP_GN_M: mul_a = coef_limit((diff_reg > 0) ? cfg.gain_open_rate
                                                       : cfg.gain_close_rate);
            OP_WT_M:
            begin
                mul_a = gain_reg;
                mul_b = DIFF_W'(wet_reg);
            end
            default: mul_a = '0;
        endcase
    end

    always_comb
    begin
        diff_next      = diff_reg;
        prod_next      = prod_reg;
        gated_next     = gated_reg;
        open_out_next  = open_out_reg;
        gate_on_next   = gate_on_reg;
        hp_next        = hp_reg;
        lp_next        = lp_reg;
        env_next       = env_reg;
        gain_next      = gain_reg;
        open_next      = open_reg;
        out_valid_next = out_valid_reg & ~out_ready;

        case (cmd.op) inside
            OP_LOAD: gate_on_next = gate_on;
            OP_HP_D: diff_next = DIFF_W'(x_val) - DIFF_W'(hp_reg);
            OP_LP_D: diff_next = DIFF_W'(h_val) - DIFF_W'(lp_reg);
            OP_EN_D: diff_next = DIFF_W'(abs_val) - DIFF_W'(env_reg);
            OP_GN_D: diff_next = $signed({{(DIFF_W-COEF_W){1'b0}}, target})
                               - $signed({{(DIFF_W-COEF_W){1'b0}}, gain_reg});
            OP_HP_M, OP_LP_M, OP_EN_M, OP_GN_M, OP_WT_M:
                prod_next = $signed({1'b0, mul_a}) * mul_b;
            OP_HP_U: hp_next = store_new;
            OP_LP_U: lp_next = store_new;
            OP_EN_U:
            begin
                env_next = store_new;
                if (!open_reg)
                    open_next = (store_new >= open_lvl);
                else
                    open_next = !(store_new < close_lvl);
            end
            OP_GN_U:
            begin
                if (gain_sum < 0)
                    gain_next = '0;
                else if (gain_sum > SUM_W'(ONE_Q24))
                    gain_next = ONE_Q24;
                else
                    gain_next = gain_sum[COEF_W-1:0];
            end
            OP_OUT:
            begin
                gated_next     = gate_on_reg ? prod_reg[FRAC_W+SAMPLE_W-1:FRAC_W] : wet_reg;
                open_out_next  = open_reg;
                out_valid_next = 1'b1;
            end
            default: diff_next = diff_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
        begin
            dry_reg <= dry_sample;
            wet_reg <= wet_sample;
        end
        diff_reg     <= diff_next;
        prod_reg     <= prod_next;
        gated_reg    <= gated_next;
        open_out_reg <= open_out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_on_reg   <= 1'b0;
            hp_reg        <= '0;
            lp_reg        <= '0;
            env_reg       <= '0;
            gain_reg      <= '0;
            open_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            gate_on_reg   <= gate_on_next;
            hp_reg        <= hp_next;
            lp_reg        <= lp_next;
            env_reg       <= env_next;
            gain_reg      <= gain_next;
            open_reg      <= open_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign sts.gate_on  = gate_on_reg;
    assign sts.out_free = ~out_valid_reg | out_ready;
    assign out_valid    = out_valid_reg;
    assign gated_sample = gated_reg;
    assign gate_is_open = open_out_reg;

endmodule

### src/hysteresis_noise_gate.sv
// Hysteresis noise gate top level: configuration, sequencer and datapath.
//
// Each sample runs through a one-pole high-pass and low-pass on the dry
// sidechain, an attack/release envelope, a two-threshold gate and a slewed
// gain that scales the wet sample. One 26 x 33 bit multiplier is shared by all
// five products: the four pole updates each take a difference, multiply and
// update step, the wet product one multiply step, then the output step, which
// waits for a free output register, loads the result. A sample with gate_on
// low goes from the high-pass difference step straight to the output step.
// The result sits in an output register, so the next sample is taken while it
// waits. Write configuration only while idle.
module hysteresis_noise_gate (
    input  logic                           clk,
    input  logic                           rst_n,
    hng_in_if.sink                         sample_ch,
    hng_out_if.source                      result_ch,
    input  logic                           cfg_we,
    input  logic [hng_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hng_pkg::CFG_DATA_W-1:0] cfg_data
);
    import hng_pkg::*;

    hng_cfg_t cfg;
    hng_cmd_t cmd;
    hng_sts_t sts;
    logic     in_ready;

    hng_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hng_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample_ch.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    hng_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg          (cfg),
        .dry_sample   (sample_ch.dry_sample),
        .wet_sample   (sample_ch.wet_sample),
        .gate_on      (sample_ch.gate_on),
        .out_valid    (result_ch.valid),
        .out_ready    (result_ch.ready),
        .gated_sample (result_ch.gated_sample),
        .gate_is_open (result_ch.gate_is_open)
    );

    assign sample_ch.ready = in_ready;

endmodule
